### hdl/slmf_pkg.sv
// Shared types and constants for the strict local maximum finder.
// Used by strict_local_maximum_finder; depends on nothing else.
package slmf_pkg;

    // grid limits and field widths
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int DIM_W      = 11;
    localparam int SAMPLE_W   = 32;
    localparam int ORD_W      = 21;
    localparam int CFG_IDX_W  = 2;

    typedef logic signed [SAMPLE_W-1:0] value_t;

    // value of every cell outside the grid
    localparam value_t PAD_VALUE = -32'sd2147483647;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_ROW  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_COL  = 2'd3;

    // result kinds
    localparam logic KIND_PEAK    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef struct packed {
        value_t sample_value;
        logic   is_flush;
    } sample_t;

    typedef struct packed {
        logic             report_kind;
        logic [ORD_W-1:0] peak_ordinal;
        logic [DIM_W-1:0] peak_row;
        logic [DIM_W-1:0] peak_col;
        logic             target_hit;
        logic             last_of_run;
    } report_t;

    // one line buffer entry: the two previous rows of one column
    typedef struct packed {
        value_t upper;
        value_t middle;
    } line_entry_t;

endpackage

### hdl/strict_local_maximum_finder.sv
// Top level of the strict 3x3 local maximum finder.
// Depends on slmf_pkg for types and constants.
//
// Usage: samples of a grid arrive on the sample channel in raster order,
// followed by one row of flush items. A transaction is taken at a clock
// edge with sample_valid high and sample_stall low. Peak reports and the
// final verdict leave on the report channel under the same rule.
// Grid size and target cell are set on the cfg port while the block is idle.
// Results pass through the stage one registers and the result queue on
// their way to the report port. Throughput: one sample per cycle while each
// sample causes at most one result and the receiver does not stall; samples
// that cause two or three results are absorbed by a four-entry result queue.
// The line buffer is one 1024 x 64 memory with one read and one write per
// cycle; a fill mark stands in for clearing it, so a new grid starts at once.
// Reset clears counters, window and queue; width and height read as 1.
// When the receiver stalls, results wait in the queue and the sample
// channel stalls once the queue cannot take three more results.
module strict_local_maximum_finder (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         sample_valid,
    output logic                         sample_stall,
    input  slmf_pkg::sample_t            sample,
    output logic                         report_valid,
    input  logic                         report_stall,
    output slmf_pkg::report_t            report,
    input  logic                         cfg_write,
    input  logic [slmf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [slmf_pkg::DIM_W-1:0]   cfg_data
);
    import slmf_pkg::*;

    localparam int QUEUE_DEPTH = 4;
    localparam int Q_IDX_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = Q_IDX_W + 1;

    // configuration registers
    logic [DIM_W-1:0] grid_width_reg;
    logic [DIM_W-1:0] grid_height_reg;
    logic [DIM_W-1:0] target_row_reg;
    logic [DIM_W-1:0] target_col_reg;

    // position counters and line buffer fill mark
    logic [DIM_W-1:0] row_reg;
    logic [COL_W-1:0] col_reg;
    logic [DIM_W-1:0] fill_reg;

    // stage one registers
    logic             s1_valid_reg;
    value_t           s1_value_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [DIM_W-1:0] s1_row_reg;
    logic             s1_last_reg;
    logic             s1_end_reg;
    logic             s1_mem_ok_reg;
    logic             fwd_hit_reg;
    line_entry_t      fwd_data_reg;
    line_entry_t      rd_data_reg;

    // window and peak bookkeeping
    value_t           win_reg [6];
    logic [ORD_W-1:0] peak_cnt_reg;
    logic             hit_seen_reg;

    // result queue
    report_t            queue_reg [QUEUE_DEPTH];
    logic [Q_IDX_W-1:0] head_reg;
    logic [Q_CNT_W-1:0] count_reg;

    // line buffer memory
    line_entry_t line_mem [MAX_WIDTH];

    function automatic logic is_peak(
        input value_t ctr, input value_t a, input value_t b, input value_t c,
        input value_t d, input value_t e, input value_t f, input value_t g,
        input value_t h);
        return (ctr > a) && (ctr > b) && (ctr > c) && (ctr > d) &&
               (ctr > e) && (ctr > f) && (ctr > g) && (ctr > h);
    endfunction

    // clamped grid size
    logic [DIM_W-1:0] width_eff;
    logic [DIM_W-1:0] height_eff;

    always_comb
    begin
        if (grid_width_reg == '0)
            width_eff = DIM_W'(1);
        else if (grid_width_reg > DIM_W'(MAX_WIDTH))
            width_eff = DIM_W'(MAX_WIDTH);
        else
            width_eff = grid_width_reg;

        if (grid_height_reg == '0)
            height_eff = DIM_W'(1);
        else if (grid_height_reg > DIM_W'(MAX_HEIGHT))
            height_eff = DIM_W'(MAX_HEIGHT);
        else
            height_eff = grid_height_reg;
    end

    // position of the incoming transaction
    logic [DIM_W-1:0] last_col_w;
    logic [COL_W-1:0] col_now;
    logic             flush_row_now;
    logic             last_now;
    logic             end_now;
    value_t           value_now;
    logic [DIM_W-1:0] col_plus_one;

    assign last_col_w    = width_eff - DIM_W'(1);
    assign col_now       = ({1'b0, col_reg} >= width_eff) ? last_col_w[COL_W-1:0] : col_reg;
    assign flush_row_now = (row_reg >= height_eff);
    assign last_now      = ({1'b0, col_now} == last_col_w);
    assign end_now       = last_now && flush_row_now;
    assign value_now     = (flush_row_now || sample.is_flush) ? PAD_VALUE : sample.sample_value;
    assign col_plus_one  = {1'b0, col_now} + DIM_W'(1);

    // handshake
    logic s1_fire;
    logic accept;
    logic pop;

    assign s1_fire      = s1_valid_reg && (count_reg <= Q_CNT_W'(1));
    assign sample_stall = s1_valid_reg && !s1_fire;
    assign accept       = sample_valid && !sample_stall;
    assign report_valid = (count_reg != '0);
    assign report       = queue_reg[head_reg];
    assign pop          = report_valid && !report_stall;

    // stage one: line buffer entry with forwarding and fill check
    line_entry_t entry;
    line_entry_t wr_entry;

    always_comb
    begin
        if (!s1_mem_ok_reg)
        begin
            entry.upper  = PAD_VALUE;
            entry.middle = PAD_VALUE;
        end
        else if (fwd_hit_reg)
            entry = fwd_data_reg;
        else
            entry = rd_data_reg;
        wr_entry.upper  = entry.middle;
        wr_entry.middle = s1_value_reg;
    end

    // stage one: window, peak tests and results
    value_t           wc [6];
    value_t           win_next [6];
    logic             peak_a;
    logic             peak_b;
    logic [ORD_W-1:0] cnt_a;
    logic [ORD_W-1:0] cnt_b;
    logic             hit_a;
    logic             hit_b;
    logic [DIM_W-1:0] s1_col_w;
    logic [DIM_W-1:0] s1_col_w1;
    report_t          res [3];
    logic [1:0]       n_res;

    always_comb
    begin
        for (int i = 0; i < 6; i++)
            wc[i] = (s1_col_reg == '0) ? PAD_VALUE : win_reg[i];

        s1_col_w  = {1'b0, s1_col_reg};
        s1_col_w1 = s1_col_w + DIM_W'(1);

        peak_a = (s1_row_reg != '0) && (s1_col_reg != '0) &&
                 is_peak(wc[4], wc[0], wc[1], wc[2], wc[3], wc[5],
                         entry.upper, entry.middle, s1_value_reg);

        win_next[0] = wc[3];
        win_next[1] = wc[4];
        win_next[2] = wc[5];
        win_next[3] = entry.upper;
        win_next[4] = entry.middle;
        win_next[5] = s1_value_reg;

        peak_b = s1_last_reg && (s1_row_reg != '0) &&
                 is_peak(win_next[4], win_next[0], win_next[1], win_next[2],
                         win_next[3], win_next[5], PAD_VALUE, PAD_VALUE, PAD_VALUE);

        cnt_a = peak_cnt_reg + ORD_W'(peak_a);
        cnt_b = cnt_a + ORD_W'(peak_b);
        hit_a = peak_a && (s1_row_reg == target_row_reg) && (s1_col_w == target_col_reg);
        hit_b = peak_b && (s1_row_reg == target_row_reg) && (s1_col_w1 == target_col_reg);

        for (int i = 0; i < 3; i++)
            res[i] = '0;
        n_res = 2'd0;

        if (peak_a)
        begin
            res[n_res].report_kind  = KIND_PEAK;
            res[n_res].peak_ordinal = cnt_a;
            res[n_res].peak_row     = s1_row_reg;
            res[n_res].peak_col     = s1_col_w;
            n_res = n_res + 2'd1;
        end
        if (peak_b)
        begin
            res[n_res].report_kind  = KIND_PEAK;
            res[n_res].peak_ordinal = cnt_b;
            res[n_res].peak_row     = s1_row_reg;
            res[n_res].peak_col     = s1_col_w1;
            n_res = n_res + 2'd1;
        end
        if (s1_end_reg)
        begin
            res[n_res].report_kind  = KIND_VERDICT;
            res[n_res].peak_ordinal = cnt_b;
            res[n_res].target_hit   = hit_seen_reg || hit_a || hit_b;
            n_res = n_res + 2'd1;
        end
        if (n_res != 2'd0)
            res[n_res - 2'd1].last_of_run = 1'b1;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= DIM_W'(1);
            grid_height_reg <= DIM_W'(1);
            target_row_reg  <= '0;
            target_col_reg  <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_GRID_WIDTH:  grid_width_reg  <= cfg_data;
                REG_GRID_HEIGHT: grid_height_reg <= cfg_data;
                REG_TARGET_ROW:  target_row_reg  <= cfg_data;
                REG_TARGET_COL:  target_col_reg  <= cfg_data;
            endcase
        end
    end

    // position counters and fill mark
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg  <= '0;
            col_reg  <= '0;
            fill_reg <= '0;
        end
        else if (accept)
        begin
            if (last_now)
            begin
                col_reg <= '0;
                if (flush_row_now)
                    row_reg <= '0;
                else
                    row_reg <= row_reg + DIM_W'(1);
            end
            else
                col_reg <= col_plus_one[COL_W-1:0];

            if (end_now)
                fill_reg <= '0;
            else if (col_plus_one > fill_reg)
                fill_reg <= col_plus_one;
        end
    end

    // stage one control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (accept)
            s1_valid_reg <= 1'b1;
        else if (s1_fire)
            s1_valid_reg <= 1'b0;
    end

    // stage one payload and forwarding
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_value_reg  <= value_now;
            s1_col_reg    <= col_now;
            s1_row_reg    <= row_reg;
            s1_last_reg   <= last_now;
            s1_end_reg    <= end_now;
            s1_mem_ok_reg <= ({1'b0, col_now} < fill_reg);
            fwd_hit_reg   <= s1_fire && (s1_col_reg == col_now);
            fwd_data_reg  <= wr_entry;
        end
    end

    // line buffer memory
    always_ff @(posedge clk)
    begin
        if (s1_fire)
            line_mem[s1_col_reg] <= wr_entry;
        if (accept)
            rd_data_reg <= line_mem[col_now];
    end

    // window and peak bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
                win_reg[i] <= PAD_VALUE;
            peak_cnt_reg <= '0;
            hit_seen_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            if (s1_end_reg)
            begin
                for (int i = 0; i < 6; i++)
                    win_reg[i] <= PAD_VALUE;
                peak_cnt_reg <= '0;
                hit_seen_reg <= 1'b0;
            end
            else
            begin
                for (int i = 0; i < 6; i++)
                    win_reg[i] <= win_next[i];
                peak_cnt_reg <= cnt_b;
                hit_seen_reg <= hit_seen_reg || hit_a || hit_b;
            end
        end
    end

    // result queue control
    logic [Q_CNT_W-1:0] count_next;
    logic [Q_IDX_W-1:0] tail;

    always_comb
    begin
        count_next = count_reg;
        if (pop)
            count_next = count_next - Q_CNT_W'(1);
        if (s1_fire)
            count_next = count_next + Q_CNT_W'(n_res);
        tail = head_reg + count_reg[Q_IDX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (pop)
                head_reg <= head_reg + Q_IDX_W'(1);
            count_reg <= count_next;
        end
    end

    // result queue storage
    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (k < int'(n_res))
                    queue_reg[tail + Q_IDX_W'(k)] <= res[k];
            end
        end
    end

endmodule
